// ----- hw/rtl/lifo_index_allocator_core_defines.svh -----
// ----------------------------------------------------------------------------
// lifo index allocator assertion macros
// shared concurrent assertion forms, sampled on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LIFO_INDEX_ALLOCATOR_CORE_DEFINES_SVH
`define LIFO_INDEX_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define LIA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lia assertion failed");

// next-cycle implication
`define LIA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lia assertion failed");

`endif

// ----- hw/rtl/lia_pkg.sv -----
// ----------------------------------------------------------------------------
// lia_pkg
// field widths, command and status codes, register indexes and shared types
// ----------------------------------------------------------------------------
package lia_pkg;

    localparam int CMD_W      = 2;
    localparam int INDEX_W    = 16;
    localparam int SLOT_W     = 12;
    localparam int OFFSET_W   = 20;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 13;
    localparam int DSIZE_W    = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int EPOCH_W    = 8;
    localparam int ADDR_W     = 16;

    localparam int CAP_RESET   = 4096;
    localparam int DSIZE_RESET = 32;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REFILL = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_DOUBLE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESC_SIZE = 1'd1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // requests from the core to the free-flag store
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_alloc;
        logic              refill;
    } flag_ctl_t;

    typedef struct packed {
        logic is_free;
        logic busy;
    } flag_sts_t;

endpackage

// ----- hw/rtl/lia_cmd_if.sv -----
// ----------------------------------------------------------------------------
// lia_cmd_if
// command channel: valid/ready with command code and slot index
// ----------------------------------------------------------------------------
interface lia_cmd_if import lia_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] index;

    modport source (output valid, cmd, index, input ready);
    modport sink (input valid, cmd, index, output ready);

endinterface

// ----- hw/rtl/lia_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lia_rsp_if
// result channel: valid/ready with slot, byte offset, status and free count
// ----------------------------------------------------------------------------
interface lia_rsp_if import lia_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] byte_offset;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;

    modport source (output valid, slot, byte_offset, status, free_count, input ready);
    modport sink (input valid, slot, byte_offset, status, free_count, output ready);

endinterface

// ----- hw/rtl/lia_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lia_cfg_if
// configuration write channel: valid/ready with register index and data
// ----------------------------------------------------------------------------
interface lia_cfg_if import lia_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);

endinterface

// ----- hw/rtl/lia_flag_mem.sv -----
// ----------------------------------------------------------------------------
// lia_flag_mem
// per-slot allocated flags in a synchronous memory, tagged with a refill epoch
// so a refill command frees every slot at once; sweeps the memory after reset
// and whenever the epoch wraps
// ----------------------------------------------------------------------------
module lia_flag_mem import lia_pkg::*; #(
    parameter int MAX_SLOTS = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    input  flag_ctl_t ctl,
    output flag_sts_t sts
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_SLOTS - 1);

    // entry: {epoch, allocated}
    logic [EPOCH_W:0] flag_mem [MAX_SLOTS];
    logic [EPOCH_W:0] rd_reg;

    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               clr_reg, clr_next;
    logic [IDX_W-1:0]   clr_addr_reg, clr_addr_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [EPOCH_W:0] wr_data;

    always_comb
    begin
        epoch_next    = epoch_reg;
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        wr_en         = 1'b0;
        wr_addr       = ctl.wr_addr[IDX_W-1:0];
        wr_data       = {epoch_reg, ctl.wr_alloc};
        if (clr_reg)
        begin
            wr_en         = 1'b1;
            wr_addr       = clr_addr_reg;
            wr_data       = '0;
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_next = 1'b0;
            end
        end
        else
        begin
            wr_en = ctl.wr_en;
            if (ctl.refill)
            begin
                epoch_next = epoch_reg + 1'b1;
                // old tags would alias after a wrap
                if (epoch_reg == '1)
                begin
                    clr_next      = 1'b1;
                    clr_addr_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg    <= '0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            epoch_reg    <= epoch_next;
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            flag_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_reg <= flag_mem[ctl.rd_addr[IDX_W-1:0]];
        end
    end

    assign sts.is_free = !(rd_reg[0] && (rd_reg[EPOCH_W:1] == epoch_reg));
    assign sts.busy    = clr_reg;

endmodule

// ----- hw/rtl/lifo_index_allocator_core.sv -----
// ----------------------------------------------------------------------------
// lifo_index_allocator_core
// slot allocator over a lifo stack of free indices with double-free detection
// ----------------------------------------------------------------------------
// A command is accepted in S_IDLE, which issues the read of the stack memory (or
// of the free-flag memory); S_EXEC then does the modify/write and loads the result
// register once the result side has room, and no new command is accepted until it
// commits. A refill is lazy: it only reloads the counters, and stack entries below
// the low-water mark since the last refill are generated from the capacity instead
// of read. After reset, and after every 256th refill command, the flag memory is
// swept, and no command is accepted during the sweep; configuration writes are
// always taken. Capacity takes effect at the next refill command and is saturated
// to MAX_SLOTS.
module lifo_index_allocator_core import lia_pkg::*; #(
    parameter int MAX_SLOTS = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    lia_cmd_if.sink   req,
    lia_rsp_if.source rsp,
    lia_cfg_if.sink   cfg
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam logic [COUNT_W-1:0] CAP_MAX  = COUNT_W'(MAX_SLOTS);
    localparam logic [COUNT_W-1:0] CAP_INIT =
        (MAX_SLOTS < CAP_RESET) ? COUNT_W'(MAX_SLOTS) : COUNT_W'(CAP_RESET);

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] capacity_reg, capacity_next;
    logic [DSIZE_W-1:0] dsize_reg, dsize_next;
    logic [COUNT_W-1:0] cap_reg, cap_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] lwm_reg, lwm_next;

    logic [CMD_W-1:0]   cmd_reg;
    logic [INDEX_W-1:0] idx_reg;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [COUNT_W-1:0]  fcount_reg, fcount_next;

    logic [IDX_W-1:0] stack_mem [MAX_SLOTS];
    logic [IDX_W-1:0] stk_rd_reg;
    logic             stk_rd_en;
    logic [IDX_W-1:0] stk_rd_addr;
    logic             stk_wr_en;
    logic [IDX_W-1:0] stk_wr_addr;
    logic [IDX_W-1:0] stk_wr_data;

    flag_ctl_t flag_ctl;
    flag_sts_t flag_sts;

    logic                     accept;
    logic                     commit;
    logic [COUNT_W-1:0]       cnt_dec;
    logic [COUNT_W-1:0]       fresh_val;
    logic [31:0]              rd_addr_w;
    logic [31:0]              wr_addr_w;
    logic [31:0]              idx_w;
    logic [31:0]              fresh_w;
    logic [31:0]              pop_w;
    logic [31:0]              prod_w;
    logic [IDX_W-1:0]         pop_val;
    logic [IDX_W+DSIZE_W-1:0] prod;
    logic [COUNT_W-1:0]       cap_sat;

    lia_flag_mem #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_flag_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (flag_ctl),
        .sts   (flag_sts)
    );

    assign cnt_dec   = count_reg - 1'b1;
    assign rd_addr_w = 32'(cnt_dec);
    assign wr_addr_w = 32'(count_reg);
    assign idx_w     = 32'(idx_reg);

    // top entry never overwritten since the refill: it is still cap-1-position
    assign fresh_val = cap_reg - count_reg;
    assign fresh_w   = 32'(fresh_val);
    assign pop_val   = (count_reg <= lwm_reg) ? fresh_w[IDX_W-1:0] : stk_rd_reg;
    assign pop_w     = 32'(pop_val);
    assign prod      = pop_val * dsize_reg;
    assign prod_w    = 32'(prod);
    assign cap_sat   = (32'(capacity_reg) > MAX_SLOTS) ? CAP_MAX : capacity_reg;

    assign accept    = req.valid && req.ready;
    assign commit    = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    assign req.ready       = (state_reg == S_IDLE) && !flag_sts.busy;
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.slot        = slot_reg;
    assign rsp.byte_offset = offset_reg;
    assign rsp.status      = status_reg;
    assign rsp.free_count  = fcount_reg;

    assign stk_rd_en   = accept;
    assign stk_rd_addr = rd_addr_w[IDX_W-1:0];

    always_comb
    begin
        capacity_next = capacity_reg;
        dsize_next    = dsize_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_CAPACITY:  capacity_next = cfg.data[COUNT_W-1:0];
                REG_DESC_SIZE: dsize_next    = cfg.data[DSIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        count_next     = count_reg;
        lwm_next       = lwm_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        slot_next      = slot_reg;
        offset_next    = offset_reg;
        status_next    = status_reg;
        fcount_next    = fcount_reg;

        stk_wr_en   = 1'b0;
        stk_wr_addr = wr_addr_w[IDX_W-1:0];
        stk_wr_data = idx_w[IDX_W-1:0];

        flag_ctl          = '0;
        flag_ctl.rd_en    = accept;
        flag_ctl.rd_addr  = req.index;
        flag_ctl.wr_addr  = 16'(pop_val);
        flag_ctl.wr_alloc = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next  = S_IDLE;
                    slot_next   = '0;
                    offset_next = '0;
                    status_next = STS_OK;
                    case (cmd_reg)
                        CMD_ALLOC:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                count_next     = cnt_dec;
                                slot_next      = pop_w[SLOT_W-1:0];
                                offset_next    = prod_w[OFFSET_W-1:0];
                                flag_ctl.wr_en = 1'b1;
                                if (cnt_dec < lwm_reg)
                                begin
                                    lwm_next = cnt_dec;
                                end
                            end
                        end
                        CMD_FREE:
                        begin
                            if (idx_w >= 32'(cap_reg))
                            begin
                                status_next = STS_RANGE;
                            end
                            else if (flag_sts.is_free)
                            begin
                                status_next = STS_DOUBLE;
                            end
                            else if (32'(count_reg) < MAX_SLOTS)
                            begin
                                stk_wr_en         = 1'b1;
                                count_next        = count_reg + 1'b1;
                                flag_ctl.wr_en    = 1'b1;
                                flag_ctl.wr_addr  = idx_reg;
                                flag_ctl.wr_alloc = 1'b0;
                            end
                        end
                        CMD_REFILL:
                        begin
                            cap_next        = cap_sat;
                            count_next      = cap_sat;
                            lwm_next        = cap_sat;
                            flag_ctl.refill = 1'b1;
                        end
                        default: ;
                    endcase
                    fcount_next    = count_next;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= COUNT_W'(CAP_RESET);
            dsize_reg     <= DSIZE_W'(DSIZE_RESET);
            cap_reg       <= CAP_INIT;
            count_reg     <= CAP_INIT;
            lwm_reg       <= CAP_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            dsize_reg     <= dsize_next;
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            lwm_reg       <= lwm_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.cmd;
            idx_reg <= req.index;
        end
        slot_reg   <= slot_next;
        offset_reg <= offset_next;
        status_reg <= status_next;
        fcount_reg <= fcount_next;
    end

    always_ff @(posedge clk)
    begin
        if (stk_wr_en)
        begin
            stack_mem[stk_wr_addr] <= stk_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_rd_en)
        begin
            stk_rd_reg <= stack_mem[stk_rd_addr];
        end
    end

endmodule

// ----- hw/rtl/lia_checker.sv -----
// ----------------------------------------------------------------------------
// lia_checker
// port-level checks on the allocator core, attached by bind
// ----------------------------------------------------------------------------
`include "lifo_index_allocator_core_defines.svh"

module lia_checker import lia_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [SLOT_W-1:0]   rsp_slot,
    input logic [OFFSET_W-1:0] rsp_byte_offset,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [COUNT_W-1:0]  rsp_free_count
);

    // one command in flight: no second word right behind an accepted one
    `LIA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

    // empty stack reports no slot and zero free count
    `LIA_ASSERT_IMPL(a_empty_result, rsp_valid && rsp_status == STS_EMPTY, rsp_free_count == '0 && rsp_slot == '0 && rsp_byte_offset == '0)

    // rejected frees carry no slot
    `LIA_ASSERT_IMPL(a_reject_no_slot, rsp_valid && (rsp_status == STS_RANGE || rsp_status == STS_DOUBLE), rsp_slot == '0 && rsp_byte_offset == '0)

    // stalled result word holds
    `LIA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_slot) && $stable(rsp_byte_offset) && $stable(rsp_status) && $stable(rsp_free_count))

endmodule

bind lifo_index_allocator_core lia_checker u_lia_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_slot        (rsp.slot),
    .rsp_byte_offset (rsp.byte_offset),
    .rsp_status      (rsp.status),
    .rsp_free_count  (rsp.free_count)
);

// ----- tb/lifo_index_allocator_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lifo_index_allocator_core_test
// drives allocate, free, refill and unused commands into the slot allocator,
// predicts each result from a private copy of the free stack and the per-slot
// free flags, and compares every result word field by field
// ----------------------------------------------------------------------------
module lifo_index_allocator_core_test;

    import lia_pkg::*;

    localparam int POOL_SLOTS   = 4096;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 70;
    localparam int DRAIN_CAP    = 160;

    // command code that the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [OFFSET_W-1:0] byte_offset;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  free_count;
    } slot_result_t;

    logic clk;
    logic rst_n;

    lia_cmd_if cmd_bus ();
    lia_rsp_if rsp_bus ();
    lia_cfg_if cfg_bus ();

    lifo_index_allocator_core #(
        .MAX_SLOTS(POOL_SLOTS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (cmd_bus),
        .rsp  (rsp_bus),
        .cfg  (cfg_bus)
    );

    // private copy of the allocator state
    logic [SLOT_W-1:0]   pool_stack [POOL_SLOTS];
    bit                  slot_free  [POOL_SLOTS];
    int unsigned         pool_depth;
    int unsigned         pool_cap;
    logic [COUNT_W-1:0]  cap_reg;
    logic [DSIZE_W-1:0]  dsize_reg;
    logic [SLOT_W-1:0]   live_slots [$];

    slot_result_t        pool_results_due [$];

    bit                  src_idle_on = 1'b1;
    bit                  sink_idle_on = 1'b1;
    int                  hold_request = 0;
    int                  hold_left;
    int                  mismatch_count = 0;
    int                  stalled_cycles = 0;
    int                  words_sent = 0;
    int                  results_checked = 0;
    int                  reg_writes = 0;
    int                  n_alloc_ok = 0;
    int                  n_empty = 0;
    int                  n_range = 0;
    int                  n_double = 0;
    int                  n_refill = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic refill_pool();
        pool_cap = (cap_reg > POOL_SLOTS) ? POOL_SLOTS : cap_reg;
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            if (i < pool_cap)
            begin
                pool_stack[i] = SLOT_W'(pool_cap - 1 - i);
                slot_free[i]  = 1'b1;
            end
            else
            begin
                pool_stack[i] = '0;
                slot_free[i]  = 1'b0;
            end
        end
        pool_depth = pool_cap;
        live_slots.delete();
    endtask

    task automatic predict_pool_result(input logic [CMD_W-1:0] c,
                                       input logic [INDEX_W-1:0] idx);
        slot_result_t r;
        int unsigned  s;
        int unsigned  prod;
        r = '0;
        r.status = STS_OK;
        case (c)
            CMD_ALLOC:
            begin
                if (pool_depth == 0 || pool_depth > POOL_SLOTS)
                begin
                    r.status = STS_EMPTY;
                    n_empty++;
                end
                else
                begin
                    pool_depth--;
                    s = pool_stack[pool_depth];
                    slot_free[s] = 1'b0;
                    prod = s * dsize_reg;
                    r.slot = s[SLOT_W-1:0];
                    r.byte_offset = prod[OFFSET_W-1:0];
                    live_slots.push_back(s[SLOT_W-1:0]);
                    n_alloc_ok++;
                end
            end
            CMD_FREE:
            begin
                if (idx >= pool_cap)
                begin
                    r.status = STS_RANGE;
                    n_range++;
                end
                else if (slot_free[idx])
                begin
                    r.status = STS_DOUBLE;
                    n_double++;
                end
                else if (pool_depth < POOL_SLOTS)
                begin
                    pool_stack[pool_depth] = idx[SLOT_W-1:0];
                    pool_depth++;
                    slot_free[idx] = 1'b1;
                    for (int k = 0; k < live_slots.size(); k++)
                    begin
                        if (live_slots[k] == idx[SLOT_W-1:0])
                        begin
                            live_slots.delete(k);
                            break;
                        end
                    end
                end
            end
            CMD_REFILL:
            begin
                refill_pool();
                n_refill++;
            end
            default:
            begin
            end
        endcase
        r.free_count = pool_depth[COUNT_W-1:0];
        pool_results_due.push_back(r);
    endtask

    // valid stays high after the handshake; only an idle cycle or wait_for_results lowers it
    task automatic send_command(input logic [CMD_W-1:0] c, input logic [INDEX_W-1:0] idx);
        while (src_idle_on && $urandom_range(99) < 36)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.cmd   <= c;
        cmd_bus.index <= idx;
        do @(posedge clk); while (!cmd_bus.ready);
        predict_pool_result(c, idx);
        words_sent++;
    endtask

    task automatic wait_for_results();
        cmd_bus.valid <= 1'b0;
        while (pool_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_pool_regs(input logic [CFG_DATA_W-1:0] cap,
                                   input logic [CFG_DATA_W-1:0] dsize);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= REG_CAPACITY;
        cfg_bus.data  <= cap;
        do @(posedge clk); while (!cfg_bus.ready);
        cap_reg = cap[COUNT_W-1:0];
        cfg_bus.index <= REG_DESC_SIZE;
        cfg_bus.data  <= dsize;
        do @(posedge clk); while (!cfg_bus.ready);
        dsize_reg = dsize[DSIZE_W-1:0];
        cfg_bus.valid <= 1'b0;
        reg_writes += 2;
    endtask

    // mostly frees of live slots and allocations, with some broken frees, refills and unused commands mixed in
    task automatic send_random_command();
        int unsigned        pick;
        logic [INDEX_W-1:0] idx;
        pick = $urandom_range(99);
        idx  = INDEX_W'($urandom_range(16'hFFFF));
        if (pick < 32 && live_slots.size() > 0)
            send_command(CMD_FREE, INDEX_W'(live_slots[$urandom_range(live_slots.size() - 1)]));
        else if (pick < 40 && pool_cap > 0)
            send_command(CMD_FREE, INDEX_W'($urandom_range(pool_cap - 1)));
        else if (pick < 46)
            send_command(CMD_FREE, idx);
        else if (pick < 48)
            send_command(CMD_REFILL, idx);
        else if (pick < 50)
            send_command(CMD_UNUSED, idx);
        else
            send_command(CMD_ALLOC, idx);
    endtask

    task automatic test_directed();
        send_command(CMD_ALLOC, 16'h0000);
        send_command(CMD_ALLOC, 16'hFFFF);
        send_command(CMD_FREE, 16'd1);
        send_command(CMD_FREE, 16'd1);
        send_command(CMD_FREE, 16'd4096);
        send_command(CMD_FREE, 16'hFFFF);
        send_command(CMD_UNUSED, 16'h5A5A);
        send_command(CMD_ALLOC, 16'h0000);
        wait_for_results();
        // new capacity stays dormant until the refill
        write_pool_regs(13'd0, 13'd1);
        send_command(CMD_ALLOC, 16'h0000);
        send_command(CMD_REFILL, 16'hFFFF);
        send_command(CMD_ALLOC, 16'h0000);
        send_command(CMD_FREE, 16'd0);
        wait_for_results();
        // capacity above the maximum saturates
        write_pool_regs(13'h1FFF, 13'd511);
        send_command(CMD_ALLOC, 16'h0000);
        send_command(CMD_REFILL, 16'h0000);
        send_command(CMD_ALLOC, 16'h0000);
        send_command(CMD_ALLOC, 16'h0000);
        send_command(CMD_FREE, 16'd0);
        send_command(CMD_FREE, 16'd0);
        wait_for_results();
        // zero descriptor size gives zero offsets
        write_pool_regs(13'd3, 13'd0);
        send_command(CMD_REFILL, 16'h0000);
        repeat (4) send_command(CMD_ALLOC, 16'h0000);
        send_command(CMD_FREE, 16'd2);
        send_command(CMD_FREE, 16'd0);
        send_command(CMD_ALLOC, 16'h0000);
        send_command(CMD_FREE, 16'd3);
        wait_for_results();
    endtask

    // drain a whole pool past empty, hand some slots back, drain again, then refill, free a slot and allocate again
    task automatic test_full_pool();
        write_pool_regs(CFG_DATA_W'(DRAIN_CAP), 13'd511);
        send_command(CMD_REFILL, 16'h0000);
        repeat (DRAIN_CAP + 1)
            send_command(CMD_ALLOC, INDEX_W'($urandom_range(16'hFFFF)));
        repeat (64)
            send_command(CMD_FREE, INDEX_W'(live_slots[$urandom_range(live_slots.size() - 1)]));
        repeat (65)
            send_command(CMD_ALLOC, 16'h0000);
        send_command(CMD_REFILL, 16'h0000);
        send_command(CMD_FREE, INDEX_W'(DRAIN_CAP - 1));
        repeat (3)
            send_command(CMD_ALLOC, 16'h0000);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        write_pool_regs(13'd40, 13'd256);
        send_command(CMD_REFILL, 16'h0000);
        hold_request = HOLD_CYCLES;
        repeat (60)
            send_random_command();
        wait_for_results();
    endtask

    task automatic test_random_phases();
        int unsigned phase_cap [8];
        int unsigned phase_dsize [8];
        phase_cap   = '{1, 2, 0, 17, 4096, 4097, 64, 0};
        phase_dsize = '{256, 1, 7, 511, 32, 8191, 0, 0};
        for (int p = 0; p < 8; p++)
        begin
            if (p == 6)
                phase_dsize[p] = $urandom_range(1, 256);
            if (p == 7)
            begin
                phase_cap[p]   = $urandom_range(13'h1FFF);
                phase_dsize[p] = $urandom_range(13'h1FFF);
            end
            write_pool_regs(CFG_DATA_W'(phase_cap[p]), CFG_DATA_W'(phase_dsize[p]));
            src_idle_on  = (p != 4);
            sink_idle_on = (p != 4);
            send_command(CMD_REFILL, INDEX_W'($urandom_range(16'hFFFF)));
            repeat (PHASE_WORDS)
                send_random_command();
            wait_for_results();
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cmd_bus.valid <= 1'b0;
        cmd_bus.cmd   <= CMD_ALLOC;
        cmd_bus.index <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= REG_CAPACITY;
        cfg_bus.data  <= '0;
        cap_reg   = COUNT_W'(CAP_RESET);
        dsize_reg = DSIZE_W'(DSIZE_RESET);
        refill_pool();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_pool();
        test_backpressure();
        test_random_phases();

        wait_for_results();
        repeat (16) @(posedge clk);
        $display("covered %0d commands, %0d results, %0d register writes, %0d refills",
                 words_sent, results_checked, reg_writes, n_refill);
        $display("allocations %0d, empty %0d, out of range %0d, double frees %0d",
                 n_alloc_ok, n_empty, n_range, n_double);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
                rsp_bus.ready <= 1'b0;
                repeat (hold_left) @(posedge clk);
            end
            rsp_bus.ready <= !sink_idle_on || ($urandom_range(99) >= 36);
        end
    end

    always @(posedge clk)
    begin
        slot_result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            results_checked++;
            if (pool_results_due.size() == 0)
            begin
                $error("result word with nothing outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pool_results_due.pop_front();
                if (rsp_bus.slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, rsp_bus.slot);
                    mismatch_count++;
                end
                if (rsp_bus.byte_offset !== want.byte_offset)
                begin
                    $error("byte_offset: expected %0d, got %0d",
                           want.byte_offset, rsp_bus.byte_offset);
                    mismatch_count++;
                end
                if (rsp_bus.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                    mismatch_count++;
                end
                if (rsp_bus.free_count !== want.free_count)
                begin
                    $error("free_count: expected %0d, got %0d",
                           want.free_count, rsp_bus.free_count);
                    mismatch_count++;
                end
            end
        end
    end

    // the limit sits well above the length of the flag sweep after reset
    always @(posedge clk)
    begin
        if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $error("no handshake for %0d cycles, %0d results outstanding",
                   stalled_cycles, pool_results_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
